[rtl/core/bezier_path_point_defines.svh]
// ----------------------------------------------------------------------------
// Bezier path point: assertion macros
// Shared assertion forms for the checkers of the Bezier path point block.
// ----------------------------------------------------------------------------
`ifndef BEZIER_PATH_POINT_DEFINES_SVH
`define BEZIER_PATH_POINT_DEFINES_SVH

// Same-cycle implication, switched off while reset is asserted.
`define BZP_ASSERT_IMP(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define BZP_ASSERT_NXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

// What must hold in the cycle after a reset edge.
`define BZP_ASSERT_RST(label, clk, rst_n, post, msg) \
  label: assert property (@(posedge clk) !rst_n |=> (post)) \
    else $error(msg);

`endif

[rtl/core/bzp_pkg.sv]
// ----------------------------------------------------------------------------
// Bezier path point package
// Field widths, curve tables and shared types of the Bezier path point block.
// ----------------------------------------------------------------------------
package bzp_pkg;

  // Widths of the word fields.
  localparam int BZP_ORG_W = 11;
  localparam int BZP_T_W   = 17;
  localparam int BZP_PT_W  = 20;

  // Width of a combined coefficient (offset times binomial).
  localparam int BZP_K_W = 15;

  // Curve orders; the quintic curve sets the number of power stages.
  localparam int BZP_NUM_CURVES = 2;
  localparam int BZP_MAX_ORDER  = 5;
  localparam int BZP_ORDER [BZP_NUM_CURVES] = '{4, 5};

  // Depth of the queue between front and back; a power of two.
  localparam int BZP_QUEUE_DEPTH = 4;

  // Control point offsets from the origin, and binomial coefficients.
  localparam int BZP_OFF_X [BZP_NUM_CURVES][BZP_MAX_ORDER+1] = '{
    '{0, -400, -400, -10, 0, 0},
    '{0, -10, -500, -200, -500, 0}
  };
  localparam int BZP_OFF_Y [BZP_NUM_CURVES][BZP_MAX_ORDER+1] = '{
    '{0, 100, 800, 800, 0, 0},
    '{0, 800, 10, 800, 800, 0}
  };
  localparam int BZP_BINOM [BZP_NUM_CURVES][BZP_MAX_ORDER+1] = '{
    '{1, 4, 6, 4, 1, 0},
    '{1, 5, 10, 10, 5, 1}
  };

  // Queue status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } bzp_qstat_t;

  // Combined x coefficient of term i of curve c.
  function automatic logic signed [BZP_K_W-1:0] bzp_kx(int c, int i);
    return BZP_K_W'(BZP_BINOM[c][i] * BZP_OFF_X[c][i]);
  endfunction

  // Combined y coefficient of term i of curve c.
  function automatic logic signed [BZP_K_W-1:0] bzp_ky(int c, int i);
    return BZP_K_W'(BZP_BINOM[c][i] * BZP_OFF_Y[c][i]);
  endfunction

endpackage

[rtl/core/bzp_if.sv]
// ----------------------------------------------------------------------------
// Bezier path point channels
// Valid/ready channels for the request word and the point word.
// ----------------------------------------------------------------------------

// Request channel: curve select, origin and curve parameter.
interface bzp_in_if import bzp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic                 func;
  logic [BZP_ORG_W-1:0] origin_x;
  logic [BZP_ORG_W-1:0] origin_y;
  logic [BZP_T_W-1:0]   param_t;

  modport source (output valid, output func, output origin_x, output origin_y,
                  output param_t, input ready);
  modport sink   (input valid, input func, input origin_x, input origin_y,
                  input param_t, output ready);
endinterface

// Result channel: one curve point per request.
interface bzp_out_if import bzp_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [BZP_PT_W-1:0] point_x;
  logic        [BZP_PT_W-1:0] point_y;

  modport source (output valid, output point_x, output point_y, input ready);
  modport sink   (input valid, input point_x, input point_y, output ready);
endinterface

[rtl/core/bzp_front.sv]
// ----------------------------------------------------------------------------
// Bezier path point front end
// Takes request words, clamps t to one, forms 1 - t and queues the result.
// ----------------------------------------------------------------------------
module bzp_front import bzp_pkg::*; #(
  parameter int T_FRAC_BITS = 16,
  localparam int QW = 1 + 2 * BZP_ORG_W + 2 * (T_FRAC_BITS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  bzp_in_if.sink        in_ch,
  input  bzp_qstat_t    q_stat,
  output logic          q_push,
  output logic [QW-1:0] q_data
);

  localparam int PW = T_FRAC_BITS + 1;
  localparam int CW = (BZP_T_W > PW) ? BZP_T_W : PW;
  localparam logic [PW-1:0] ONE = {1'b1, {T_FRAC_BITS{1'b0}}};

  logic          f_vld_r, f_vld_nxt;
  logic [QW-1:0] f_word_r;
  logic          in_acc;
  logic [CW-1:0] t_ext;
  logic [PW-1:0] t_clamp, u_val;

  // The holding register frees itself whenever the queue has room.
  assign q_push      = f_vld_r && !q_stat.full;
  assign in_ch.ready = !f_vld_r || !q_stat.full;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign q_data      = f_word_r;

  // Saturate t at one and form the complementary weight 1 - t.
  always_comb begin
    t_ext   = CW'(in_ch.param_t);
    t_clamp = (t_ext > CW'(ONE)) ? ONE : t_ext[PW-1:0];
    u_val   = ONE - t_clamp;
  end

  always_comb begin
    f_vld_nxt = f_vld_r;
    if (in_acc) begin
      f_vld_nxt = 1'b1;
    end else if (q_push) begin
      f_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_vld_r <= 1'b0;
    end else begin
      f_vld_r <= f_vld_nxt;
    end
  end

  // Payload register; it loads on each accepted request and holds otherwise.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      f_word_r <= {in_ch.func, in_ch.origin_x, in_ch.origin_y, t_clamp, u_val};
    end
  end

endmodule

[rtl/core/bzp_queue.sv]
// ----------------------------------------------------------------------------
// Bezier path point queue
// Small register queue that decouples the front end from the evaluator.
// ----------------------------------------------------------------------------
module bzp_queue import bzp_pkg::*; #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] pop_data,
  output bzp_qstat_t   stat
);

  localparam int AW = $clog2(BZP_QUEUE_DEPTH);

  logic [W-1:0]  mem_r [BZP_QUEUE_DEPTH];
  logic [AW-1:0] wr_ptr_r, rd_ptr_r;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (AW+1)'(BZP_QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign cnt_nxt    = cnt_r + (AW+1)'(push) - (AW+1)'(pop);

  // Pointers wrap on their own since the depth is a power of two.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/bzp_back.sv]
// ----------------------------------------------------------------------------
// Bezier path point evaluator
// Pipeline that raises t and 1 - t to their powers, forms the Bernstein
// weights, sums the weighted offsets and rounds into the output register.
// ----------------------------------------------------------------------------
module bzp_back import bzp_pkg::*; #(
  parameter int T_FRAC_BITS   = 16,
  parameter int OUT_FRAC_BITS = 8,
  localparam int QW = 1 + 2 * BZP_ORG_W + 2 * (T_FRAC_BITS + 1)
) (
  input  logic          clk,
  input  logic          rst_n,
  input  bzp_qstat_t    q_stat,
  input  logic [QW-1:0] q_data,
  output logic          q_pop,
  bzp_out_if.source     out_ch
);

  localparam int NP = BZP_MAX_ORDER;
  localparam int N0 = BZP_ORDER[0];
  localparam int N1 = BZP_ORDER[1];
  localparam int PW = T_FRAC_BITS + 1;
  localparam int TW = PW + BZP_K_W + 1;
  localparam int SW = TW + 3;
  localparam int RW = SW + OUT_FRAC_BITS + 2;
  localparam int SH_R = (T_FRAC_BITS > OUT_FRAC_BITS) ? T_FRAC_BITS - OUT_FRAC_BITS : 0;
  localparam int SH_L = (T_FRAC_BITS > OUT_FRAC_BITS) ? 0 : OUT_FRAC_BITS - T_FRAC_BITS;

  localparam logic [PW-1:0]   ONE  = {1'b1, {T_FRAC_BITS{1'b0}}};
  localparam logic [2*PW-1:0] HALF = {{(PW+1){1'b0}}, 1'b1, {(T_FRAC_BITS-1){1'b0}}};
  localparam logic signed [RW-1:0] RND  = (RW'(1) <<< SH_R) >>> 1;
  localparam logic signed [RW-1:0] XMIN = -(RW'(1) <<< (BZP_PT_W - 1));
  localparam logic signed [RW-1:0] XMAX = (RW'(1) <<< (BZP_PT_W - 1)) - 1;
  localparam logic signed [RW-1:0] YMAX = (RW'(1) <<< BZP_PT_W) - 1;

  typedef logic [PW-1:0]          pw_t;
  typedef logic [NP:0][PW-1:0]    pvec_t;
  typedef struct packed {
    logic                 func;
    logic [BZP_ORG_W-1:0] ox;
    logic [BZP_ORG_W-1:0] oy;
  } side_t;

  // Rounded fixed-point product, half up.
  function automatic pw_t rmul(pw_t a, pw_t b);
    logic [2*PW-1:0] p;
    p = {{PW{1'b0}}, a} * {{PW{1'b0}}, b} + HALF;
    return p[T_FRAC_BITS +: PW];
  endfunction

  logic  adv;
  side_t q_side;
  pw_t   q_t, q_u;

  // Power stages: stage s holds t^k and (1-t)^k for k up to s + 1.
  logic [NP-1:0] pv_r;
  side_t         ps_r [NP];
  pvec_t         tp_r [NP];
  pvec_t         up_r [NP];
  pvec_t         tp_nxt [NP];
  pvec_t         up_nxt [NP];

  // Weight, term and sum stages.
  logic                   wv_r, tv_r, sv_r;
  side_t                  ws_r, ts_r, ss_r;
  logic [NP:0][PW-1:0]    m_r, m_nxt;
  logic signed [TW-1:0]   tx_r [NP+1];
  logic signed [TW-1:0]   ty_r [NP+1];
  logic signed [TW-1:0]   tx_nxt [NP+1];
  logic signed [TW-1:0]   ty_nxt [NP+1];
  logic signed [SW-1:0]   sx_r, sy_r, sx_nxt, sy_nxt;

  // Output register.
  logic                       out_vld_r;
  logic signed [BZP_PT_W-1:0] px_r, px_nxt;
  logic        [BZP_PT_W-1:0] py_r, py_nxt;

  // The whole pipeline moves whenever the output register can take a word.
  assign adv   = !out_vld_r || out_ch.ready;
  assign q_pop = adv && !q_stat.empty;
  assign {q_side, q_t, q_u} = q_data;

  assign out_ch.valid   = out_vld_r;
  assign out_ch.point_x = px_r;
  assign out_ch.point_y = py_r;

  // One new power of t and of 1 - t per stage.
  always_comb begin
    tp_nxt[0]    = {(NP+1){ONE}};
    up_nxt[0]    = {(NP+1){ONE}};
    tp_nxt[0][1] = q_t;
    up_nxt[0][1] = q_u;
    for (int s = 1; s < NP; s++) begin
      tp_nxt[s]      = tp_r[s-1];
      up_nxt[s]      = up_r[s-1];
      tp_nxt[s][s+1] = rmul(tp_r[s-1][s], tp_r[s-1][1]);
      up_nxt[s][s+1] = rmul(up_r[s-1][s], up_r[s-1][1]);
    end
  end

  // Bernstein products t^i (1-t)^(n-i), one lane per term.
  always_comb begin
    pw_t ua;
    pw_t ub;
    for (int i = 0; i <= NP; i++) begin
      ua       = (i <= N0) ? up_r[NP-1][(i <= N0) ? (N0 - i) : 0] : '0;
      ub       = (i <= N1) ? up_r[NP-1][(i <= N1) ? (N1 - i) : 0] : '0;
      m_nxt[i] = rmul(tp_r[NP-1][i], ps_r[NP-1].func ? ub : ua);
    end
  end

  // Scale each product by its binomial times control point offset.
  always_comb begin
    logic signed [BZP_K_W-1:0] kx;
    logic signed [BZP_K_W-1:0] ky;
    for (int i = 0; i <= NP; i++) begin
      kx        = ws_r.func ? bzp_kx(1, i) : bzp_kx(0, i);
      ky        = ws_r.func ? bzp_ky(1, i) : bzp_ky(0, i);
      tx_nxt[i] = $signed({1'b0, m_r[i]}) * kx;
      ty_nxt[i] = $signed({1'b0, m_r[i]}) * ky;
    end
  end

  // Sum the weighted offsets.
  always_comb begin
    sx_nxt = '0;
    sy_nxt = '0;
    for (int i = 0; i <= NP; i++) begin
      sx_nxt = sx_nxt + SW'(tx_r[i]);
      sy_nxt = sy_nxt + SW'(ty_r[i]);
    end
  end

  // Round to the output precision, add the origin and saturate.
  always_comb begin
    logic signed [RW-1:0] rx;
    logic signed [RW-1:0] ry;
    logic signed [RW-1:0] ox_e;
    logic signed [RW-1:0] oy_e;
    rx   = ((RW'(sx_r) + RND) >>> SH_R) <<< SH_L;
    ry   = ((RW'(sy_r) + RND) >>> SH_R) <<< SH_L;
    ox_e = RW'({1'b0, ss_r.ox});
    oy_e = RW'({1'b0, ss_r.oy});
    rx   = rx + (ox_e <<< OUT_FRAC_BITS);
    ry   = ry + (oy_e <<< OUT_FRAC_BITS);
    if (rx < XMIN) begin
      rx = XMIN;
    end else if (rx > XMAX) begin
      rx = XMAX;
    end
    if (ry < 0) begin
      ry = '0;
    end else if (ry > YMAX) begin
      ry = YMAX;
    end
    px_nxt = rx[BZP_PT_W-1:0];
    py_nxt = ry[BZP_PT_W-1:0];
  end

  // Valid chain through the pipeline.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r      <= '0;
      wv_r      <= 1'b0;
      tv_r      <= 1'b0;
      sv_r      <= 1'b0;
      out_vld_r <= 1'b0;
    end else if (adv) begin
      pv_r      <= {pv_r[NP-2:0], q_pop};
      wv_r      <= pv_r[NP-1];
      tv_r      <= wv_r;
      sv_r      <= tv_r;
      out_vld_r <= sv_r;
    end
  end

  // Payload registers; all hold while the output is stalled.
  always_ff @(posedge clk) begin
    if (adv) begin
      ps_r[0] <= q_side;
      for (int s = 0; s < NP; s++) begin
        tp_r[s] <= tp_nxt[s];
        up_r[s] <= up_nxt[s];
      end
      for (int s = 1; s < NP; s++) begin
        ps_r[s] <= ps_r[s-1];
      end
      ws_r <= ps_r[NP-1];
      m_r  <= m_nxt;
      ts_r <= ws_r;
      for (int i = 0; i <= NP; i++) begin
        tx_r[i] <= tx_nxt[i];
        ty_r[i] <= ty_nxt[i];
      end
      ss_r <= ts_r;
      sx_r <= sx_nxt;
      sy_r <= sy_nxt;
      px_r <= px_nxt;
      py_r <= py_nxt;
    end
  end

endmodule

[rtl/core/bezier_path_point.sv]
// ----------------------------------------------------------------------------
// Bezier path point
// Evaluates a point on one of two fixed Bezier loop paths around an origin.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one request word: func picks the quartic (0) or quintic (1)
//   loop path, origin_x and origin_y give the start point in pixels and
//   param_t gives t with T_FRAC_BITS fraction bits; values above one clamp.
//   out_ch returns one word per request, in order: point_x (signed) and
//   point_y, each with OUT_FRAC_BITS fraction bits, rounded to nearest.
//   Both channels move a word at a clock edge where valid and ready are high.
// Path and throughput:
//   A request passes through the front register, the queue, five power
//   stages, the weight, term and sum stages, and the output register.
//   While out_ch.ready stays high, one word is taken and one returned every
//   cycle.
// Reset and stalls:
//   Reset empties the front register, the queue and the pipeline; no word
//   is in flight afterwards. While out_ch.ready is low the evaluator holds
//   still, the queue and then the front register fill, and in_ch.ready drops.
// ----------------------------------------------------------------------------
module bezier_path_point import bzp_pkg::*; #(
  parameter int T_FRAC_BITS   = 16,
  parameter int OUT_FRAC_BITS = 8
) (
  input  logic      clk,
  input  logic      rst_n,
  bzp_in_if.sink    in_ch,
  bzp_out_if.source out_ch
);

  localparam int QW = 1 + 2 * BZP_ORG_W + 2 * (T_FRAC_BITS + 1);

  bzp_qstat_t    q_stat;
  logic          q_push, q_pop;
  logic [QW-1:0] q_wr_data, q_rd_data;

  // Front end: accept, clamp and queue.
  bzp_front #(
    .T_FRAC_BITS (T_FRAC_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_wr_data)
  );

  // Decoupling queue.
  bzp_queue #(
    .W (QW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wr_data),
    .pop       (q_pop),
    .pop_data  (q_rd_data),
    .stat      (q_stat)
  );

  // Evaluator pipeline and output register.
  bzp_back #(
    .T_FRAC_BITS   (T_FRAC_BITS),
    .OUT_FRAC_BITS (OUT_FRAC_BITS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_stat (q_stat),
    .q_data (q_rd_data),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

[rtl/core/bzp_checker.sv]
// ----------------------------------------------------------------------------
// Bezier path point checker
// Port-level checks of the Bezier path point block, bound to the top level.
// ----------------------------------------------------------------------------
`include "bezier_path_point_defines.svh"

module bzp_checker import bzp_pkg::*; (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [BZP_PT_W-1:0] point_x,
  input logic        [BZP_PT_W-1:0] point_y
);

  logic       in_acc, out_acc;
  logic [4:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Words accepted but not yet returned.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else begin
      pend_r <= pend_r + 5'(in_acc) - 5'(out_acc);
    end
  end

  // A stalled result stays offered and unchanged.
  `BZP_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "result withdrawn while stalled")
  `BZP_ASSERT_NXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(point_x) && $stable(point_y), "result changed while stalled")

  // Nothing is offered right after reset.
  `BZP_ASSERT_RST(a_rst_empty, clk, rst_n, !out_valid, "result offered after reset")

  // Every result answers an earlier request.
  `BZP_ASSERT_IMP(a_no_extra, clk, rst_n, out_acc, pend_r != '0, "result without a request")

endmodule

bind bezier_path_point bzp_checker u_bzp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .point_x   (out_ch.point_x),
  .point_y   (out_ch.point_y)
);
